// File: src/dml2t_pkg.sv
// Shared types and constants of the direct-mapped L2 tag and timing controller.
// Depends on nothing; every other file of the block uses it.
package dml2t_pkg;

    localparam int unsigned CD_W      = 13;           // countdown width, holds hit + memory latency
    localparam int unsigned OUTW_W    = 11;           // outstanding word counter
    localparam logic [10:0] OUTW_MAX  = 11'd2047;
    localparam logic [31:0] POISON_TAG = 32'hFFFF_FFFF;
    localparam int unsigned PADDR_W   = 5;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_STORE  = 2'd2,
        CMD_ATOMIC = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        OUT_HIT      = 3'd0,
        OUT_MISS     = 3'd1,
        OUT_FAULT    = 3'd2,
        OUT_BANK     = 3'd3,
        OUT_BW       = 3'd4,
        OUT_QFULL    = 3'd5,
        OUT_STORE_OR = 3'd6,
        OUT_TICK     = 3'd7
    } t_outcome;

    typedef enum logic [2:0] {
        REG_LWL    = 3'd0,
        REG_HIT    = 3'd1,
        REG_MEM    = 3'd2,
        REG_DRAIN  = 3'd3,
        REG_LIMIT  = 3'd4,
        REG_WORDS  = 3'd5,
        REG_BYPASS = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_TICK
    } t_state;

    typedef struct packed {
        logic [2:0]  line_words_log2;
        logic [7:0]  hit_cycles;
        logic [11:0] mem_latency;
        logic [7:0]  drain_per_tick;
        logic [9:0]  outstanding_limit;
        logic [31:0] mem_words;
        logic        bypass;
    } t_cfg;

    typedef struct packed {
        logic clear_step;
        logic take;
        logic exec;
        logic walk;
    } t_dp_ctrl;

    typedef struct packed {
        logic clear_done;
        logic bank_rdy;
        logic walk_last;
        logic out_free;
    } t_dp_status;

endpackage

// File: src/dml2t_cfg.sv
// Configuration register file behind the APB-style port.
// Depends on dml2t_pkg.
module dml2t_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dml2t_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output dml2t_pkg::t_cfg                   o_cfg
);
    dml2t_pkg::t_cfg r_cfg;
    logic            w_wr;

    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_words_log2   <= 3'd2;
            r_cfg.hit_cycles        <= 8'd1;
            r_cfg.mem_latency       <= 12'd100;
            r_cfg.drain_per_tick    <= 8'd8;
            r_cfg.outstanding_limit <= 10'd256;
            r_cfg.mem_words         <= 32'd4194304;
            r_cfg.bypass            <= 1'b0;
        end else if (w_wr) begin
            case (dml2t_pkg::t_reg_idx'(paddr[4:2]))
                dml2t_pkg::REG_LWL:    r_cfg.line_words_log2   <= pwdata[2:0];
                dml2t_pkg::REG_HIT:    r_cfg.hit_cycles        <= pwdata[7:0];
                dml2t_pkg::REG_MEM:    r_cfg.mem_latency       <= pwdata[11:0];
                dml2t_pkg::REG_DRAIN:  r_cfg.drain_per_tick    <= pwdata[7:0];
                dml2t_pkg::REG_LIMIT:  r_cfg.outstanding_limit <= pwdata[9:0];
                dml2t_pkg::REG_WORDS:  r_cfg.mem_words         <= pwdata;
                dml2t_pkg::REG_BYPASS: r_cfg.bypass            <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (dml2t_pkg::t_reg_idx'(paddr[4:2]))
            dml2t_pkg::REG_LWL:    prdata = {29'd0, r_cfg.line_words_log2};
            dml2t_pkg::REG_HIT:    prdata = {24'd0, r_cfg.hit_cycles};
            dml2t_pkg::REG_MEM:    prdata = {20'd0, r_cfg.mem_latency};
            dml2t_pkg::REG_DRAIN:  prdata = {24'd0, r_cfg.drain_per_tick};
            dml2t_pkg::REG_LIMIT:  prdata = {22'd0, r_cfg.outstanding_limit};
            dml2t_pkg::REG_WORDS:  prdata = r_cfg.mem_words;
            dml2t_pkg::REG_BYPASS: prdata = {31'd0, r_cfg.bypass};
            default:               prdata = 32'd0;
        endcase
    end
endmodule

// File: src/dml2t_ctrl.sv
// Sequencer: clearing pass, item intake, access execution and fill-queue walk.
// Depends on dml2t_pkg; drives the datapath through t_dp_ctrl.
module dml2t_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic [1:0]              i_command,
    output logic                    o_in_stall,
    input  dml2t_pkg::t_dp_status   i_status,
    output dml2t_pkg::t_dp_ctrl     o_ctrl
);
    dml2t_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dml2t_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        o_in_stall = 1'b1;
        case (r_state)
            dml2t_pkg::ST_CLEAR: begin
                o_ctrl.clear_step = 1'b1;
                if (i_status.clear_done) n_state = dml2t_pkg::ST_IDLE;
            end
            dml2t_pkg::ST_IDLE: begin
                o_in_stall  = !i_status.out_free;
                o_ctrl.take = i_in_valid && i_status.out_free;
                if (o_ctrl.take) begin
                    n_state = (dml2t_pkg::t_cmd'(i_command) == dml2t_pkg::CMD_TICK) ?
                              dml2t_pkg::ST_TICK : dml2t_pkg::ST_EXEC;
                end
            end
            dml2t_pkg::ST_EXEC: begin
                // hold until the bank number is known
                o_ctrl.exec = i_status.bank_rdy;
                if (i_status.bank_rdy) n_state = dml2t_pkg::ST_IDLE;
            end
            dml2t_pkg::ST_TICK: begin
                o_ctrl.walk = 1'b1;
                if (i_status.walk_last) n_state = dml2t_pkg::ST_IDLE;
            end
            default: n_state = dml2t_pkg::ST_CLEAR;
        endcase
    end
endmodule

// File: src/dml2t_dp.sv
// Datapath: tag memory, fill queue, bank flags, traffic counter, result register.
// Depends on dml2t_pkg; controlled by dml2t_ctrl.
module dml2t_dp #(
    parameter int unsigned LINES      = 4096,
    parameter int unsigned BANKS      = 4,
    parameter int unsigned FILL_SLOTS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  dml2t_pkg::t_cfg         i_cfg,
    input  dml2t_pkg::t_dp_ctrl     i_ctrl,
    output dml2t_pkg::t_dp_status   o_status,
    input  logic [1:0]              i_command,
    input  logic [31:0]             i_address,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_accepted,
    output logic [2:0]              o_outcome,
    output logic [15:0]             o_latency
);
    localparam int unsigned IW   = $clog2(LINES);
    localparam int unsigned BW   = (BANKS > 1) ? $clog2(BANKS) : 1;
    localparam int unsigned SW   = (FILL_SLOTS > 1) ? $clog2(FILL_SLOTS) : 1;
    localparam int unsigned CNTW = $clog2(FILL_SLOTS + 1);
    localparam int unsigned CW   = dml2t_pkg::CD_W;

    // tag memory: {valid, tag}
    logic [32:0] mem [LINES];
    logic [32:0] r_rd;
    logic [IW-1:0] w_rd_addr, w_wr_addr;
    logic [32:0]   w_wr_data;
    logic          w_wr_en;
    logic [IW-1:0] r_clr;

    logic [IW-1:0] q_ix  [FILL_SLOTS];
    logic [31:0]   q_tag [FILL_SLOTS];
    logic [CW-1:0] q_cd  [FILL_SLOTS];
    logic [CNTW-1:0] r_count, r_kept;
    logic [SW-1:0]   r_walk;

    logic [BANKS-1:0] r_bank_used;
    logic [10:0]      r_outw;

    logic [1:0]    r_cmd;
    logic [31:0]   r_addr;
    logic [IW-1:0] r_index;
    logic [31:0]   r_tag;
    logic [BW-1:0] w_bank;
    logic          w_bank_rdy;

    logic          r_out_valid, r_acc;
    logic [2:0]    r_outc;
    logic [15:0]   r_lat;

    logic [IW-1:0] w_in_ix;
    logic [31:0]   w_in_tag;
    logic [32:0]   w_keep_mask;

    // result of one access
    logic        e_acc, e_traffic, e_enq, e_poison, e_bank;
    logic [2:0]  e_outc;
    logic [15:0] e_lat, w_lat_mem;
    logic        w_found, w_conflict, w_bw_blk, w_full;
    logic [CW-1:0] w_found_cd;
    logic [11:0] w_traffic_sum;
    logic [10:0] w_traffic;
    logic        w_walk_zero;

    assign w_in_ix     = IW'(i_address >> i_cfg.line_words_log2);
    assign w_keep_mask = ~((33'd1 << (6'(IW) + 6'(i_cfg.line_words_log2))) - 33'd1);
    assign w_in_tag    = i_address & w_keep_mask[31:0];

    // ---------------- bank number ----------------
    generate
        if ((BANKS & (BANKS - 1)) == 0) begin : g_bank_pow2
            if (BANKS == 1) begin : g_one
                assign w_bank = '0;
            end else begin : g_many
                assign w_bank = r_addr[BW-1:0];
            end
            assign w_bank_rdy = 1'b1;
        end else begin : g_bank_serial
            // remainder one address nibble a cycle, from the top nibble down
            logic [BW-1:0] r_rem;
            logic [3:0]    r_bcnt;
            logic [3:0]    w_nib;
            logic [BW+3:0] w_step [5];
            assign w_nib      = r_addr[5'd28 - {r_bcnt[2:0], 2'b00} +: 4];
            assign w_bank     = r_rem;
            assign w_bank_rdy = r_bcnt[3];
            always_comb begin
                w_step[0] = {r_rem, w_nib};
                for (int j = 0; j < 4; j++) begin
                    w_step[j+1] = (w_step[j] >= (BW+4)'(BANKS << (3 - j))) ?
                                  w_step[j] - (BW+4)'(BANKS << (3 - j)) : w_step[j];
                end
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_bcnt <= 4'd8;
                end else if (i_ctrl.take) begin
                    r_bcnt <= 4'd0;
                end else if (!r_bcnt[3]) begin
                    r_bcnt <= r_bcnt + 4'd1;
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_ctrl.take) begin
                    r_rem <= '0;
                end else if (!r_bcnt[3]) begin
                    r_rem <= BW'(w_step[4]);
                end
            end
        end
    endgenerate

    // ---------------- tag memory ----------------
    assign w_rd_addr = i_ctrl.take ? w_in_ix : r_index;

    always_ff @(posedge i_clk) begin
        r_rd <= mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) mem[w_wr_addr] <= w_wr_data;
    end

    assign w_walk_zero = (r_count != '0) && (q_cd[r_walk] == '0);

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_index;
        w_wr_data = {r_rd[32], dml2t_pkg::POISON_TAG};
        if (i_ctrl.clear_step) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_clr;
            w_wr_data = '0;
        end else if (i_ctrl.walk) begin
            w_wr_en   = w_walk_zero;
            w_wr_addr = q_ix[r_walk];
            w_wr_data = {1'b1, q_tag[r_walk]};
        end else if (i_ctrl.exec) begin
            w_wr_en = e_poison;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_ctrl.clear_step) begin
            r_clr <= r_clr + IW'(1);
        end
    end

    // ---------------- access decision ----------------
    always_comb begin
        w_found    = 1'b0;
        w_found_cd = '0;
        for (int i = FILL_SLOTS - 1; i >= 0; i--) begin
            if (CNTW'(i) < r_count && q_ix[i] == r_index && q_tag[i] == r_tag) begin
                w_found    = 1'b1;
                w_found_cd = q_cd[i];
            end
        end
    end

    assign w_conflict    = r_bank_used[w_bank] && !i_cfg.bypass;
    assign w_bw_blk      = r_outw >= 11'(i_cfg.outstanding_limit);
    assign w_full        = r_count >= CNTW'(FILL_SLOTS);
    assign w_lat_mem     = 16'(i_cfg.hit_cycles) + 16'(i_cfg.mem_latency);
    assign w_traffic_sum = 12'(r_outw) + (12'd1 << i_cfg.line_words_log2);
    assign w_traffic     = (w_traffic_sum > 12'(dml2t_pkg::OUTW_MAX)) ?
                           dml2t_pkg::OUTW_MAX : w_traffic_sum[10:0];

    always_comb begin
        e_acc = 1'b1; e_traffic = 1'b0; e_enq = 1'b0; e_poison = 1'b0; e_bank = 1'b0;
        e_outc = dml2t_pkg::OUT_MISS;
        e_lat  = '0;
        case (dml2t_pkg::t_cmd'(r_cmd))
            dml2t_pkg::CMD_LOAD: begin
                if (r_addr >= i_cfg.mem_words) begin
                    e_outc = dml2t_pkg::OUT_FAULT;
                end else if (w_conflict) begin
                    e_acc = 1'b0; e_outc = dml2t_pkg::OUT_BANK;
                end else if (!i_cfg.bypass && r_rd[32] && r_rd[31:0] == r_tag) begin
                    e_outc = dml2t_pkg::OUT_HIT;
                    e_lat  = 16'(i_cfg.hit_cycles);
                    e_bank = 1'b1;
                end else if (w_found) begin
                    e_outc = (w_found_cd != '0) ? dml2t_pkg::OUT_MISS : dml2t_pkg::OUT_HIT;
                    e_lat  = 16'(i_cfg.hit_cycles) + 16'(w_found_cd);
                    e_bank = 1'b1;
                end else if (w_bw_blk) begin
                    e_acc = 1'b0; e_outc = dml2t_pkg::OUT_BW;
                end else if (w_full) begin
                    e_acc = 1'b0; e_outc = dml2t_pkg::OUT_QFULL;
                end else begin
                    e_traffic = 1'b1; e_enq = 1'b1; e_bank = 1'b1;
                    e_lat = w_lat_mem;
                end
            end
            dml2t_pkg::CMD_STORE: begin
                if (w_conflict) begin
                    e_acc = 1'b0; e_outc = dml2t_pkg::OUT_BANK;
                end else if (w_bw_blk) begin
                    e_acc = 1'b0; e_outc = dml2t_pkg::OUT_BW;
                end else begin
                    e_traffic = 1'b1; e_bank = 1'b1;
                    e_lat  = w_lat_mem;
                    e_outc = (r_addr >= i_cfg.mem_words) ?
                             dml2t_pkg::OUT_STORE_OR : dml2t_pkg::OUT_MISS;
                end
            end
            dml2t_pkg::CMD_ATOMIC: begin
                if (w_conflict) begin
                    e_acc = 1'b0; e_outc = dml2t_pkg::OUT_BANK;
                end else begin
                    e_poison = (r_rd[31:0] == r_tag);
                    e_bank   = 1'b1;
                    e_lat    = w_lat_mem;
                end
            end
            default: e_outc = dml2t_pkg::OUT_TICK;
        endcase
    end

    // ---------------- item registers ----------------
    always_ff @(posedge i_clk) begin
        if (i_ctrl.take) begin
            r_cmd   <= i_command;
            r_addr  <= i_address;
            r_index <= w_in_ix;
            r_tag   <= w_in_tag;
        end
    end

    // ---------------- traffic and bank flags ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outw      <= '0;
            r_bank_used <= '0;
        end else if (i_ctrl.take &&
                     dml2t_pkg::t_cmd'(i_command) == dml2t_pkg::CMD_TICK) begin
            r_outw      <= (r_outw > 11'(i_cfg.drain_per_tick)) ?
                           r_outw - 11'(i_cfg.drain_per_tick) : '0;
            r_bank_used <= '0;
        end else if (i_ctrl.exec) begin
            if (e_traffic) r_outw <= w_traffic;
            if (e_bank) r_bank_used[w_bank] <= 1'b1;
        end
    end

    // ---------------- fill queue ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_walk  <= '0;
            r_kept  <= '0;
        end else if (i_ctrl.take) begin
            r_walk <= '0;
            r_kept <= '0;
        end else if (i_ctrl.exec && e_enq) begin
            r_count <= r_count + CNTW'(1);
        end else if (i_ctrl.walk && r_count != '0) begin
            // compact in place: survivors move down to r_kept
            r_walk <= r_walk + SW'(1);
            if (!w_walk_zero) r_kept <= r_kept + CNTW'(1);
            if (o_status.walk_last) r_count <= r_kept + CNTW'(!w_walk_zero);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.exec && e_enq) begin
            q_ix[r_count[SW-1:0]]  <= r_index;
            q_tag[r_count[SW-1:0]] <= r_tag;
            q_cd[r_count[SW-1:0]]  <= CW'(w_lat_mem);
        end else if (i_ctrl.walk && r_count != '0 && !w_walk_zero) begin
            q_ix[r_kept[SW-1:0]]  <= q_ix[r_walk];
            q_tag[r_kept[SW-1:0]] <= q_tag[r_walk];
            q_cd[r_kept[SW-1:0]]  <= q_cd[r_walk] - CW'(1);
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.exec ||
                     (i_ctrl.take && dml2t_pkg::t_cmd'(i_command) == dml2t_pkg::CMD_TICK)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.exec) begin
            r_acc  <= e_acc;
            r_outc <= e_outc;
            r_lat  <= e_lat;
        end else if (i_ctrl.take && dml2t_pkg::t_cmd'(i_command) == dml2t_pkg::CMD_TICK) begin
            r_acc  <= 1'b1;
            r_outc <= dml2t_pkg::OUT_TICK;
            r_lat  <= '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_accepted  = r_acc;
    assign o_outcome   = r_outc;
    assign o_latency   = r_lat;

    assign o_status.clear_done = (r_clr == IW'(LINES - 1));
    assign o_status.bank_rdy   = w_bank_rdy;
    assign o_status.walk_last  = (r_count == '0) || (CNTW'(r_walk) == r_count - CNTW'(1));
    assign o_status.out_free   = !r_out_valid || !i_out_stall;
endmodule

// File: src/direct_mapped_l2_tag_timing_top.sv
// Top level of the direct-mapped L2 tag and timing controller.
// Depends on dml2t_pkg, dml2t_cfg, dml2t_ctrl and dml2t_dp.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-----------------------------
//  in       | in        | i_in_valid / o_in_stall   | i_command, i_address
//  out      | out       | o_out_valid / i_out_stall | o_accepted, o_outcome, o_latency
//  config   | in        | psel, penable, pready     | paddr, pwrite, pwdata, prdata
//
// After reset the tag memory is swept, one line a cycle through all LINES lines
// (4096 by default), with o_in_stall high. Loads, stores and atomics take a tag
// read and then a decision, and an atomic may write a poison tag back; when BANKS
// is not a power of two the decision waits for the bank, found by a remainder
// taken one address nibble a cycle. A tick walks the fill queue; the walk writes
// at most one landed fill per cycle into the tags.
// A result waits in the output register; a new item is taken as it leaves.
module direct_mapped_l2_tag_timing_top #(
    parameter int unsigned LINES      = 4096,
    parameter int unsigned BANKS      = 4,
    parameter int unsigned FILL_SLOTS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_command,
    input  logic [31:0]                   i_address,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_accepted,
    output logic [2:0]                    o_outcome,
    output logic [15:0]                   o_latency,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dml2t_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    dml2t_pkg::t_cfg       w_cfg;
    dml2t_pkg::t_dp_ctrl   w_ctrl;
    dml2t_pkg::t_dp_status w_status;

    dml2t_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    dml2t_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_ctrl     (w_ctrl)
    );

    dml2t_dp #(
        .LINES      (LINES),
        .BANKS      (BANKS),
        .FILL_SLOTS (FILL_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_ctrl      (w_ctrl),
        .o_status    (w_status),
        .i_command   (i_command),
        .i_address   (i_address),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_accepted  (o_accepted),
        .o_outcome   (o_outcome),
        .o_latency   (o_latency)
    );
endmodule

// File: src/dml2t_chk.sv
// Port-level checks on the controller's result channel.
// Depends on dml2t_pkg; bound to direct_mapped_l2_tag_timing_top.
module dml2t_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_accepted,
    input logic [2:0]  o_outcome,
    input logic [15:0] o_latency,
    input logic        pready
);
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid) else $error("result valid after reset");

    a_stall_zero_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_accepted |-> o_latency == 16'd0)
        else $error("refused transaction carries a latency");

    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_outcome == dml2t_pkg::OUT_TICK |-> o_accepted && o_latency == 16'd0)
        else $error("tick result malformed");

    a_fault_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_outcome == dml2t_pkg::OUT_FAULT |-> o_accepted && o_latency == 16'd0)
        else $error("fault result malformed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall && pready |=> o_out_valid && $stable(o_latency))
        else $error("stalled result changed");
endmodule

bind direct_mapped_l2_tag_timing_top dml2t_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_accepted  (o_accepted),
    .o_outcome   (o_outcome),
    .o_latency   (o_latency),
    .pready      (pready)
);
